[rtl/qrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// shared widths, codes and the queue item type of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W     = 24;
  localparam int ROOT_W     = 32;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int DISC_W     = 2 * COEF_W + 4;
  localparam int SQ_W       = 2 * COEF_W + 2;
  localparam int SQR_W      = COEF_W + 1;
  localparam int NUM_W      = COEF_W + 3;
  localparam int DIV_W      = NUM_W - 1 + FRAC_SHIFT;
  localparam int DEN_W      = COEF_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_LVL_W    = $clog2(Q_DEPTH) + 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL  = 2'd1;

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_ONE  = 2'd1;
  localparam logic [1:0] CLS_TWO  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_AZERO = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  // magnitude of the most negative root
  localparam logic [DIV_W-1:0] ROOT_LIM =
    {{(DIV_W-ROOT_W){1'b0}}, 1'b1, {(ROOT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic [SQ_W-1:0]          disc;
    logic [1:0]               cls;
    logic                     a_zero;
  } qrs_item_t;

endpackage
`default_nettype wire

[rtl/qrs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_front
// takes coefficients, forms the discriminant and classifies the equation
// ----------------------------------------------------------------------------
module qrs_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [qrs_pkg::COEF_W-1:0]  coef_a,
  input  wire logic [qrs_pkg::COEF_W-1:0]  coef_b,
  input  wire logic [qrs_pkg::COEF_W-1:0]  coef_c,
  input  wire logic [qrs_pkg::TOL_W-1:0]   tol,
  input  wire logic [qrs_pkg::Q_LVL_W-1:0] q_level,
  output logic                             busy,
  output logic                             push,
  output qrs_pkg::qrs_item_t               item
);
  import qrs_pkg::*;

  logic                     accept;
  logic                     s1_valid;
  logic signed [COEF_W-1:0] s1_a;
  logic signed [COEF_W-1:0] s1_b;
  logic [PROD_W-1:0]        s1_bsq;
  logic signed [PROD_W-1:0] s1_ac;
  logic [COEF_W-1:0]        ub;
  logic [Q_LVL_W-1:0]       used;
  logic signed [DISC_W-1:0] m;
  logic signed [DISC_W-1:0] d;
  logic signed [DISC_W-1:0] tolx;

  // credit check: queue entries plus the item in flight
  assign used   = q_level + Q_LVL_W'(s1_valid);
  assign busy   = used >= Q_LVL_W'(Q_DEPTH);
  assign accept = start && !busy;
  assign ub     = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_a   <= $signed(coef_a);
      s1_b   <= $signed(coef_b);
      s1_bsq <= ub * ub;
      s1_ac  <= $signed(coef_a) * $signed(coef_c);
    end
  end

  // d = 4*(floor(b*b/4) - a*c) + (b odd)
  always_comb begin
    m    = $signed({{(DISC_W-PROD_W+2){1'b0}}, s1_bsq[PROD_W-1:2]})
         - {{(DISC_W-PROD_W){s1_ac[PROD_W-1]}}, s1_ac};
    d    = {m[DISC_W-3:0], 1'b0, s1_bsq[0]};
    tolx = $signed({{(DISC_W-TOL_W){1'b0}}, tol});
    item.a      = s1_a;
    item.b      = s1_b;
    item.disc   = d[SQ_W-1:0];
    item.a_zero = (s1_a == '0);
    if (d < -tolx) begin
      item.cls = CLS_NONE;
    end else if (d <= tolx) begin
      item.cls = CLS_ONE;
    end else begin
      item.cls = CLS_TWO;
    end
  end

  assign push = s1_valid;

endmodule
`default_nettype wire

[rtl/qrs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_queue
// small queue of classified equations between front and back
// ----------------------------------------------------------------------------
module qrs_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire qrs_pkg::qrs_item_t          push_item,
  input  wire logic                        pop,
  output qrs_pkg::qrs_item_t               head,
  output logic                             empty,
  output logic [qrs_pkg::Q_LVL_W-1:0]      level
);
  import qrs_pkg::*;

  qrs_item_t          slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp;
  logic [Q_PTR_W-1:0] rp;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  assign head  = slots[rp];
  assign empty = (level == '0);

endmodule
`default_nettype wire

[rtl/qrs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_back
// square root, rounding divide and biquadratic expansion, then root output
// ----------------------------------------------------------------------------
module qrs_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        mode,
  input  wire logic                        q_empty,
  input  wire qrs_pkg::qrs_item_t          q_head,
  output logic                             pop,
  output logic                             root_valid,
  output logic [qrs_pkg::ROOT_W-1:0]       root_value,
  output logic [1:0]                       root_index,
  output logic [2:0]                       root_total,
  output logic                             root_present,
  output logic [1:0]                       status_code,
  output logic                             last_result
);
  import qrs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_SQD   = 3'd2;
  localparam logic [2:0] S_DST   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EXP   = 3'd5;
  localparam logic [2:0] S_SQY   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]        st;
  qrs_item_t         ent;
  logic [SQR_W-1:0]  sroot;
  logic [ROOT_W-1:0] qv [2];
  logic              qs [2];
  logic              qi;
  logic              two;
  logic [ROOT_W-1:0] rv [4];
  logic              rs [4];
  logic [2:0]        nr;
  logic [1:0]        ei;

  // square root engine
  logic [SQ_W-1:0] sq_n;
  logic [SQ_W-1:0] sq_res;
  logic [SQ_W-1:0] sq_bit;
  logic [SQ_W-1:0] sq_trial;
  logic [SQ_W-1:0] sq_n_next;
  logic [SQ_W-1:0] sq_res_next;
  logic [SQ_W-1:0] sq_arg;

  // divide engine
  logic [DEN_W-1:0]     dv_rem;
  logic [DIV_W-1:0]     dv_q;
  logic [DEN_W-1:0]     dv_den;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic                 dv_neg;
  logic [DEN_W:0]       dv_trial;
  logic                 dv_ge;
  logic [DEN_W-1:0]     dv_rem_next;
  logic [DIV_W-1:0]     dv_q_next;
  logic [ROOT_W-1:0]    dv_val;
  logic                 dv_sat;

  // divide setup
  logic signed [NUM_W-1:0] nb;
  logic signed [NUM_W-1:0] se;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-2:0]        un;
  logic [COEF_W-1:0]       ua;
  logic [DIV_W-1:0]        ds_dividend;
  logic [DEN_W-1:0]        ds_den;
  logic                    ds_neg;

  logic [ROOT_W-1:0] y;
  logic [ROOT_W-1:0] sq_pos;

  always_comb begin
    sq_trial = sq_res + sq_bit;
    if (sq_n >= sq_trial) begin
      sq_n_next   = sq_n - sq_trial;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_n_next   = sq_n;
      sq_res_next = sq_res >> 1;
    end
  end

  always_comb begin
    dv_trial    = {dv_rem, dv_q[DIV_W-1]};
    dv_ge       = dv_trial >= {1'b0, dv_den};
    dv_rem_next = dv_ge ? DEN_W'(dv_trial - {1'b0, dv_den}) : dv_trial[DEN_W-1:0];
    dv_q_next   = {dv_q[DIV_W-2:0], dv_ge};
    dv_sat      = 1'b0;
    if (dv_neg) begin
      if (dv_q_next > ROOT_LIM) begin
        dv_val = {1'b1, {(ROOT_W-1){1'b0}}};
        dv_sat = 1'b1;
      end else begin
        dv_val = ~dv_q_next[ROOT_W-1:0] + 1'b1;
      end
    end else begin
      if (dv_q_next > ROOT_LIM - 1'b1) begin
        dv_val = {1'b0, {(ROOT_W-1){1'b1}}};
        dv_sat = 1'b1;
      end else begin
        dv_val = dv_q_next[ROOT_W-1:0];
      end
    end
  end

  // numerator -b -/+ sqrt d, scaled so the quotient is a rounded Q16.16 value
  always_comb begin
    nb  = -{{(NUM_W-COEF_W){ent.b[COEF_W-1]}}, ent.b};
    se  = $signed({{(NUM_W-SQR_W){1'b0}}, sroot});
    num = qi ? (nb + se) : (nb - se);
    un  = num[NUM_W-1] ? (NUM_W-1)'(-num) : (NUM_W-1)'(num);
    ua  = ent.a[COEF_W-1] ? COEF_W'(-ent.a) : COEF_W'(ent.a);
    ds_dividend = {un, {FRAC_SHIFT{1'b0}}} + {{(DIV_W-COEF_W){1'b0}}, ua};
    ds_den      = {ua, 1'b0};
    ds_neg      = num[NUM_W-1] ^ ent.a[COEF_W-1];
  end

  assign y      = qv[qi];
  assign sq_arg = {{(SQ_W-ROOT_W-FRAC_SHIFT+1){1'b0}}, y[ROOT_W-2:0], {FRAC_SHIFT{1'b0}}};
  assign sq_pos = {{(ROOT_W-SQR_W){1'b0}}, sq_res_next[SQR_W-1:0]};
  assign pop    = (st == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      root_valid <= 1'b0;
    end else begin
      root_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (!q_empty) begin
            ent <= q_head;
            st  <= S_CLASS;
          end
        end
        S_CLASS: begin
          qi <= 1'b0;
          nr <= '0;
          ei <= '0;
          if (ent.a_zero || ent.cls == CLS_NONE) begin
            st <= S_EMIT;
          end else if (ent.cls == CLS_ONE) begin
            two   <= 1'b0;
            sroot <= '0;
            st    <= S_DST;
          end else begin
            two    <= 1'b1;
            sq_n   <= ent.disc;
            sq_res <= '0;
            sq_bit <= {2'b01, {(SQ_W-2){1'b0}}};
            st     <= S_SQD;
          end
        end
        S_SQD: begin
          sq_n   <= sq_n_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            sroot <= sq_res_next[SQR_W-1:0];
            st    <= S_DST;
          end
        end
        S_DST: begin
          dv_rem <= '0;
          dv_q   <= ds_dividend;
          dv_den <= ds_den;
          dv_neg <= ds_neg;
          dv_cnt <= '0;
          st     <= S_DIV;
        end
        S_DIV: begin
          dv_rem <= dv_rem_next;
          dv_q   <= dv_q_next;
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_cnt == DIV_CNT_W'(DIV_W - 1)) begin
            qv[qi] <= dv_val;
            qs[qi] <= dv_sat;
            if (two && !qi) begin
              qi <= 1'b1;
              st <= S_DST;
            end else if (!mode) begin
              rv[0] <= qi ? qv[0] : dv_val;
              rs[0] <= qi ? qs[0] : dv_sat;
              rv[1] <= dv_val;
              rs[1] <= dv_sat;
              nr    <= two ? 3'd2 : 3'd1;
              st    <= S_EMIT;
            end else begin
              qi <= 1'b0;
              st <= S_EXP;
            end
          end
        end
        S_EXP: begin
          if (y != '0 && !y[ROOT_W-1]) begin
            sq_n   <= sq_arg;
            sq_res <= '0;
            sq_bit <= {2'b01, {(SQ_W-2){1'b0}}};
            st     <= S_SQY;
          end else begin
            if (y == '0) begin
              rv[nr[1:0]] <= '0;
              rs[nr[1:0]] <= qs[qi];
              nr          <= nr + 1'b1;
            end
            if (two && !qi) begin
              qi <= 1'b1;
            end else begin
              st <= S_EMIT;
            end
          end
        end
        S_SQY: begin
          sq_n   <= sq_n_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            rv[nr[1:0]]        <= ~sq_pos + 1'b1;
            rs[nr[1:0]]        <= qs[qi];
            rv[nr[1:0] + 1'b1] <= sq_pos;
            rs[nr[1:0] + 1'b1] <= qs[qi];
            nr                 <= nr + 3'd2;
            if (two && !qi) begin
              qi <= 1'b1;
              st <= S_EXP;
            end else begin
              st <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          root_valid <= 1'b1;
          if (nr == '0) begin
            root_value   <= '0;
            root_index   <= '0;
            root_total   <= '0;
            root_present <= 1'b0;
            status_code  <= ent.a_zero ? STAT_AZERO : STAT_OK;
            last_result  <= 1'b1;
            st           <= S_IDLE;
          end else begin
            root_value   <= rv[ei];
            root_index   <= ei;
            root_total   <= nr;
            root_present <= 1'b1;
            status_code  <= rs[ei] ? STAT_SAT : STAT_OK;
            last_result  <= ({1'b0, ei} == nr - 1'b1);
            ei           <= ei + 1'b1;
            if ({1'b0, ei} == nr - 1'b1) begin
              st <= S_IDLE;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/quadratic_root_solver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2+b*x+c (or a*x^4+b*x^2+c) in fixed point
// ----------------------------------------------------------------------------
// usage
//   input: coef_a/b/c (signed Q8.16) transfer at a clock edge with start high
//   and busy low. busy rises when the four-entry queue plus the item in the
//   multiply stage would be full.
//   output: one result per root, each shown for a single cycle with
//   root_valid high; last_result marks the final one of an equation. an
//   equation with no root or a zero leading coefficient gives one result with
//   root_present low. the receiver cannot stall the output.
//   config: cfg_write with cfg_index 0 (mode) or 1 (zero tolerance), only
//   while the block is idle.
// timing
//   front: an item reaches the queue the cycle after its transfer; one
//   equation per cycle while busy is low. back: one equation at a time;
//   a bit-serial sqrt of d, a rounding divide per quadratic root, in
//   biquadratic mode a bit-serial sqrt per positive quadratic root, then the
//   results in order; the bit-serial sqrt and divide loop sets the rate.
// reset
//   rst clears the queue, the sequencer and both config registers.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [qrs_pkg::COEF_W-1:0]     coef_a,
  input  wire logic [qrs_pkg::COEF_W-1:0]     coef_b,
  input  wire logic [qrs_pkg::COEF_W-1:0]     coef_c,
  input  wire logic                           cfg_write,
  input  wire logic [qrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qrs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                root_valid,
  output logic [qrs_pkg::ROOT_W-1:0]          root_value,
  output logic [1:0]                          root_index,
  output logic [2:0]                          root_total,
  output logic                                root_present,
  output logic [1:0]                          status_code,
  output logic                                last_result
);
  import qrs_pkg::*;

  logic               equation_mode;
  logic [TOL_W-1:0]   zero_tolerance;
  logic               push;
  qrs_item_t          push_item;
  logic               pop;
  qrs_item_t          head;
  logic               q_empty;
  logic [Q_LVL_W-1:0] q_level;

  // config registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      equation_mode  <= 1'b0;
      zero_tolerance <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE: equation_mode  <= cfg_data[0];
        REG_TOL:  zero_tolerance <= cfg_data[TOL_W-1:0];
        default:  ;
      endcase
    end
  end

  // multiply and classify
  qrs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .coef_a  (coef_a),
    .coef_b  (coef_b),
    .coef_c  (coef_c),
    .tol     (zero_tolerance),
    .q_level (q_level),
    .busy    (busy),
    .push    (push),
    .item    (push_item)
  );

  // decouples the front, one equation per cycle while not busy, from the iterative back
  qrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .level     (q_level)
  );

  // sqrt, divide, expansion and result sequencing
  qrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mode         (equation_mode),
    .q_empty      (q_empty),
    .q_head       (head),
    .pop          (pop),
    .root_valid   (root_valid),
    .root_value   (root_value),
    .root_index   (root_index),
    .root_total   (root_total),
    .root_present (root_present),
    .status_code  (status_code),
    .last_result  (last_result)
  );

`ifndef ASSERT_OFF
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    root_valid && root_present |-> ({1'b0, root_index} < root_total))
    else $error("root index beyond root total");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root_present |-> last_result && root_total == 3'd0)
    else $error("no-root result malformed");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= Q_LVL_W'(Q_DEPTH))
    else $error("queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[test/qrs_root_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_root_checker
// watches the quadratic root solver ports, predicts every root of each
// accepted equation and compares the emitted roots in order
// ----------------------------------------------------------------------------
module qrs_root_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [qrs_pkg::COEF_W-1:0]     coef_a,
  input  wire logic [qrs_pkg::COEF_W-1:0]     coef_b,
  input  wire logic [qrs_pkg::COEF_W-1:0]     coef_c,
  input  wire logic                           cfg_write,
  input  wire logic [qrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           root_valid,
  input  wire logic [qrs_pkg::ROOT_W-1:0]     root_value,
  input  wire logic [1:0]                     root_index,
  input  wire logic [2:0]                     root_total,
  input  wire logic                           root_present,
  input  wire logic [1:0]                     status_code,
  input  wire logic                           last_result,
  output int                                  fail_count,
  output int                                  roots_pending
);
  import qrs_pkg::*;

  typedef struct {
    logic [ROOT_W-1:0] value;
    logic [1:0]        index;
    logic [2:0]        total;
    logic              present;
    logic [1:0]        status;
    logic              last;
  } root_t;

  root_t       expected_roots[$];
  logic        biquad_mode;
  logic [15:0] disc_tol;

  initial fail_count = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_root(longint v, inout bit sat);
    longint hi, lo;
    hi = (longint'(1) << (ROOT_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1;
      return hi;
    end
    if (v < lo) begin
      sat = 1;
      return lo;
    end
    return v;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    bit neg;
    longint unsigned un, ud, q;
    neg = (num < 0) != (den < 0);
    un  = num < 0 ? -num : num;
    ud  = den < 0 ? -den : den;
    q   = (2 * un + ud) / (2 * ud);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic push_root(longint v, int k, int tot, bit pres, logic [1:0] st, bit lst);
    root_t e;
    e.value   = v[ROOT_W-1:0];
    e.index   = k[1:0];
    e.total   = tot[2:0];
    e.present = pres;
    e.status  = st;
    e.last    = lst;
    expected_roots.push_back(e);
  endtask

  task automatic predict_roots(logic [COEF_W-1:0] ra, logic [COEF_W-1:0] rb,
                               logic [COEF_W-1:0] rc);
    longint a, b, c, m, r, d, tol, sv, y, sq;
    longint unsigned ub, q, s;
    longint qv[2], rv[4];
    bit     qs[2], rs[4];
    int     nq, nr, cls;
    bit     f0, f1;
    a  = longint'(signed'(ra));
    b  = longint'(signed'(rb));
    c  = longint'(signed'(rc));
    nq = 0;
    nr = 0;
    if (a == 0) begin
      push_root(0, 0, 0, 0, STAT_AZERO, 1);
      return;
    end
    // d = 4m + r, kept exact
    ub  = b < 0 ? -b : b;
    m   = longint'((ub * ub) >> 2) - a * c;
    r   = longint'(ub & 1);
    tol = longint'(disc_tol);
    if (m < -(longint'(1) << 40)) cls = 0;
    else if (m > (longint'(1) << 40)) cls = 2;
    else begin
      d   = 4 * m + r;
      cls = d < -tol ? 0 : (d <= tol ? 1 : 2);
    end
    if (cls == 1) begin
      qs[0] = 0;
      qv[0] = clamp_root(round_div(-b * 32768, a), qs[0]);
      nq    = 1;
    end else if (cls == 2) begin
      q     = int_sqrt(longint'(m));
      s     = 2 * q + ((q * q + q + longint'(1 - r) <= longint'(m)) ? 1 : 0);
      sv    = longint'(s);
      qs[0] = 0;
      qs[1] = 0;
      qv[0] = clamp_root(round_div((-b - sv) * 32768, a), qs[0]);
      qv[1] = clamp_root(round_div((-b + sv) * 32768, a), qs[1]);
      nq    = 2;
    end
    for (int i = 0; i < nq; i++) begin
      if (!biquad_mode) begin
        rv[nr] = qv[i];
        rs[nr] = qs[i];
        nr++;
      end else begin
        y = qv[i];
        if (y == 0) begin
          rv[nr] = 0;
          rs[nr] = qs[i];
          nr++;
        end else if (y > 0) begin
          sq = longint'(int_sqrt(longint'(y) << 16));
          f0 = qs[i];
          f1 = qs[i];
          rv[nr] = clamp_root(-sq, f0);
          rs[nr] = f0;
          nr++;
          rv[nr] = clamp_root(sq, f1);
          rs[nr] = f1;
          nr++;
        end
      end
    end
    if (nr == 0) begin
      push_root(0, 0, 0, 0, STAT_OK, 1);
      return;
    end
    for (int i = 0; i < nr; i++)
      push_root(rv[i], i, nr, 1, rs[i] ? STAT_SAT : STAT_OK, i == nr - 1);
  endtask

  task automatic check_root();
    root_t e;
    if (expected_roots.size() == 0) begin
      $display("%0t: unexpected root value %h", $time, root_value);
      fail_count++;
      return;
    end
    e = expected_roots.pop_front();
    if (root_value !== e.value || root_index !== e.index || root_total !== e.total ||
        root_present !== e.present || status_code !== e.status ||
        last_result !== e.last) begin
      $display("%0t: root mismatch expected val %h idx %0d tot %0d pres %0d st %0d last %0d",
               $time, e.value, e.index, e.total, e.present, e.status, e.last);
      $display("%0t:               actual   val %h idx %0d tot %0d pres %0d st %0d last %0d",
               $time, root_value, root_index, root_total, root_present, status_code,
               last_result);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_roots.delete();
      biquad_mode = 0;
      disc_tol    = 0;
    end else begin
      if (root_valid) check_root();
      if (cfg_write) begin
        if (cfg_index == REG_MODE) biquad_mode = cfg_data[0];
        else if (cfg_index == REG_TOL) disc_tol = cfg_data[15:0];
      end
      if (start && !busy) predict_roots(coef_a, coef_b, coef_c);
    end
    roots_pending = expected_roots.size();
  end

endmodule

[test/tb_quadratic_root_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// drives directed and random equations through the root solver in several
// register settings and idle patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam logic [COEF_W-1:0] ONE = 24'h010000;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  start = 0;
  logic [COEF_W-1:0]     coef_a = '0;
  logic [COEF_W-1:0]     coef_b = '0;
  logic [COEF_W-1:0]     coef_c = '0;
  logic                  cfg_write = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy, root_valid, root_present, last_result;
  logic [ROOT_W-1:0]     root_value;
  logic [1:0]            root_index, status_code;
  logic [2:0]            root_total;
  int                    fail_count, roots_pending;
  int                    idle_pct;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  quadratic_root_solver DUT (.*);

  qrs_root_checker checker_i (.*);

  // hard stop well beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("quadratic_root_solver test failed");
    $finish;
  end

  // hold one equation on the inputs until its transfer, then maybe go idle
  task automatic send_equation(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                               logic [COEF_W-1:0] c);
    start  <= 1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop sending and let the back end drain before touching registers
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (roots_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  // random equation: mostly built around chosen roots, some plain noise
  task automatic send_random();
    logic [COEF_W-1:0] a, b, c;
    int                sel;
    longint            r1, r2, av;
    sel = $urandom_range(99);
    if (sel < 25) begin
      a = COEF_W'($urandom);
      b = COEF_W'($urandom);
      c = COEF_W'($urandom);
    end else if (sel < 30) begin
      a = '0;
      b = COEF_W'($urandom);
      c = COEF_W'($urandom);
    end else begin
      // a*(x-r1)*(x-r2), roots of a few units, either sign
      av = longint'($urandom_range(1, 4 * 65536)) * ($urandom_range(1) ? 1 : -1);
      r1 = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
      r2 = $urandom_range(3) == 0 ? r1 : longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
      a  = av[COEF_W-1:0];
      b  = COEF_W'(-(av * (r1 + r2)) >>> 16);
      c  = COEF_W'(((av * r1) >>> 16) * r2 >>> 16);
      // nudge c now and then to land near a zero discriminant
      if ($urandom_range(3) == 0)
        c = COEF_W'(longint'(c) + longint'($urandom_range(0, 6)) - 3);
    end
    send_equation(a, b, c);
  endtask

  task automatic run_directed();
    send_equation('0, ONE, ONE);                          // leading coefficient zero
    send_equation(ONE, '0, ONE);                          // no real root
    send_equation(ONE, 24'h020000, ONE);                  // double root at -1
    send_equation(ONE, '0, 24'hFF0000);                   // roots -1 and 1
    send_equation(ONE, 24'hFD0000, 24'h020000);           // roots 1 and 2
    send_equation(ONE, 24'h000000, 24'h000000);           // root at zero
    send_equation(24'h000001, 24'h7FFFFF, '0);            // saturating root
    send_equation(24'h000001, 24'h800000, '0);            // saturating the other way
    send_equation(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_equation(24'h800000, 24'h800000, 24'h800000);
    send_equation(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    send_equation(24'h7FFFFF, 24'h800000, 24'h800000);
    send_equation(24'hFFFFFF, 24'h000001, 24'h000000);
    send_equation(ONE, 24'h000001, 24'h000000);           // tiny odd discriminant
    send_equation(ONE, 24'h000002, 24'h000001);           // small negative discriminant
    send_equation(ONE, 24'h000003, 24'h000003);           // slightly negative
    send_equation(24'hFF0000, 24'h010000, 24'h020000);    // negative leading term
    send_equation(24'h000001, 24'h000000, 24'h7FFFFF);
  endtask

  initial begin
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed set in every mode and tolerance extreme
    run_directed();
    write_reg(REG_MODE, 16'd1);
    run_directed();
    write_reg(REG_TOL, 16'hFFFF);
    run_directed();
    write_reg(REG_MODE, 16'd0);
    idle_pct = 17;
    run_directed();

    // random phases, each with its own setting and an idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TOL, CFG_DATA_W'($urandom_range(0, 65535)));
          idle_pct = 0;
        end
        1: begin
          write_reg(REG_MODE, 16'd1);
          write_reg(REG_TOL, 16'd0);
          idle_pct = 49;
        end
        2: begin
          write_reg(REG_TOL, 16'hFFFF);
          idle_pct = 0;
        end
        default: begin
          write_reg(REG_MODE, CFG_DATA_W'($urandom) | 16'h1);
          write_reg(REG_TOL, CFG_DATA_W'($urandom));
          idle_pct = 17;
        end
      endcase
      for (int n = 0; n < 60; n++) send_random();
      if (ph == 3) write_reg(REG_MODE, 16'd0);
    end

    drain();
    if (fail_count == 0) begin
      $display("quadratic_root_solver test passed");
    end else begin
      $display("quadratic_root_solver test failed");
    end
    $finish;
  end

endmodule
